// File: hdl/gccs_pkg.sv
// gccs_pkg: types, constants and the triangle case table for the contour block
// used by gccs_ratio_pipe and grid_cell_contour_segments
// depends on nothing
`default_nettype none

package gccs_pkg;

   localparam int VAL_W      = 32;
   localparam int LIDX_W     = 8;
   localparam int FRAC_W     = 32;
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = FRAC_W / DIV_BITS;

   // input item: one cell at one level
   typedef struct packed {
      logic [VAL_W-1:0]  value_left_low;
      logic [VAL_W-1:0]  value_left_high;
      logic [VAL_W-1:0]  value_right_high;
      logic [VAL_W-1:0]  value_right_low;
      logic [VAL_W-1:0]  x_left;
      logic [VAL_W-1:0]  x_right;
      logic [VAL_W-1:0]  y_low;
      logic [VAL_W-1:0]  y_high;
      logic [VAL_W-1:0]  level;
      logic [LIDX_W-1:0] level_index;
   } gccs_req_type;

   // result item: one segment
   typedef struct packed {
      logic [VAL_W-1:0]  x_start;
      logic [VAL_W-1:0]  y_start;
      logic [VAL_W-1:0]  x_end;
      logic [VAL_W-1:0]  y_end;
      logic [LIDX_W-1:0] segment_level;
      logic              last_segment;
   } gccs_rsp_type;

   // vertex class against the level
   typedef enum logic [1:0] {
      CLS_EQ    = 2'b00,
      CLS_ABOVE = 2'b01,
      CLS_BELOW = 2'b10
   } gccs_cls_type;

   // vertex role inside a triangle: corner, next corner, centre
   typedef enum logic [1:0] {
      ROLE_P = 2'b00,
      ROLE_Q = 2'b01,
      ROLE_C = 2'b10
   } gccs_role_type;

   // segment plan of one triangle: start point (a1,b1), end point (a2,b2)
   typedef struct packed {
      logic          emit;
      gccs_role_type a1;
      gccs_role_type b1;
      gccs_role_type a2;
      gccs_role_type b2;
   } gccs_plan_type;

   // one interpolated point, anchor coordinate plus offset magnitude and sign
   typedef struct packed {
      logic [VAL_W-1:0] cb_x;
      logic [VAL_W-1:0] cb_y;
      logic [VAL_W-1:0] mag_x;
      logic [VAL_W-1:0] mag_y;
      logic             neg_x;
      logic             neg_y;
   } gccs_pt_type;

   typedef struct packed {
      gccs_pt_type [1:0] pt;
      logic [LIDX_W-1:0] lidx;
      logic              last;
   } gccs_seg_type;

   // divider pipe word: partial remainder, denominator, quotient per point
   typedef struct packed {
      logic [1:0][FRAC_W-1:0] rem;
      logic [1:0][FRAC_W-1:0] den;
      logic [1:0][FRAC_W-1:0] quo;
      gccs_seg_type           seg;
   } gccs_div_type;

   function automatic gccs_plan_type mk_plan(gccs_role_type a1, gccs_role_type b1,
                                             gccs_role_type a2, gccs_role_type b2);
      gccs_plan_type p;
      p.emit = 1'b1;
      p.a1   = a1;
      p.b1   = b1;
      p.a2   = a2;
      p.b2   = b2;
      return p;
   endfunction

   // triangle case table over the classes of corner, next corner and centre
   function automatic gccs_plan_type tri_plan(gccs_cls_type cp, gccs_cls_type cq,
                                              gccs_cls_type cc);
      gccs_plan_type p;
      p.emit = 1'b0;
      p.a1   = ROLE_P;
      p.b1   = ROLE_P;
      p.a2   = ROLE_P;
      p.b2   = ROLE_P;
      if (cp == CLS_EQ && cq == CLS_EQ) begin
         p = mk_plan(ROLE_P, ROLE_P, ROLE_Q, ROLE_Q);
      end else if (cp == CLS_EQ && cc == CLS_EQ) begin
         p = mk_plan(ROLE_P, ROLE_P, ROLE_C, ROLE_C);
      end else if (cq == CLS_EQ && cc == CLS_EQ) begin
         p = mk_plan(ROLE_Q, ROLE_Q, ROLE_C, ROLE_C);
      end else if (cp == CLS_EQ) begin
         if (cq != cc) p = mk_plan(ROLE_P, ROLE_P, ROLE_Q, ROLE_C);
      end else if (cq == CLS_EQ) begin
         if (cp != cc) p = mk_plan(ROLE_Q, ROLE_Q, ROLE_P, ROLE_C);
      end else if (cc == CLS_EQ) begin
         if (cp != cq) p = mk_plan(ROLE_C, ROLE_C, ROLE_P, ROLE_Q);
      end else if (cp != cq && cq == cc) begin
         p = mk_plan(ROLE_P, ROLE_Q, ROLE_P, ROLE_C);
      end else if (cp == cc && cp != cq) begin
         p = mk_plan(ROLE_Q, ROLE_P, ROLE_Q, ROLE_C);
      end else if (cp == cq && cp != cc) begin
         p = mk_plan(ROLE_C, ROLE_P, ROLE_C, ROLE_Q);
      end
      return p;
   endfunction

   // vertex number of a role in triangle t (centre is vertex 4)
   function automatic logic [2:0] vidx(gccs_role_type r, logic [1:0] t);
      logic [2:0] v;
      case (r)
         ROLE_P:  v = {1'b0, t};
         ROLE_Q:  v = {1'b0, t + 2'd1};
         ROLE_C:  v = 3'd4;
         default: v = 3'd4;
      endcase
      return v;
   endfunction

   // magnitude of a 33-bit signed difference, always below 2^32
   function automatic logic [VAL_W-1:0] mag33(logic [VAL_W:0] d);
      logic [VAL_W:0] m;
      m = d[VAL_W] ? (~d + 1'b1) : d;
      return m[VAL_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/gccs_ratio_pipe.sv
// gccs_ratio_pipe: pipelined restoring divider giving two 32-bit fractions n/d
// DIV_BITS quotient bits per stage, segment payload rides along
// depends on gccs_pkg
`default_nettype none

module gccs_ratio_pipe import gccs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_vld,
   input  gccs_div_type in_word,
   output logic         out_vld,
   output gccs_div_type out_word
);

   gccs_div_type st_ff [DIV_STAGES];
   gccs_div_type st_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff;

   // DIV_BITS restoring steps on both points
   function automatic gccs_div_type div_step(gccs_div_type d);
      gccs_div_type o;
      logic [FRAC_W:0] r2;
      o = d;
      for (int j = 0; j < 2; j++) begin
         for (int k = 0; k < DIV_BITS; k++) begin
            r2 = {o.rem[j], 1'b0};
            if (r2 >= {1'b0, o.den[j]}) begin
               r2 = r2 - {1'b0, o.den[j]};
               o.quo[j] = {o.quo[j][FRAC_W-2:0], 1'b1};
            end else begin
               o.quo[j] = {o.quo[j][FRAC_W-2:0], 1'b0};
            end
            o.rem[j] = r2[FRAC_W-1:0];
         end
      end
      return o;
   endfunction

   // next value of every stage
   always_comb begin
      st_in[0] = div_step(in_word);
      for (int s = 1; s < DIV_STAGES; s++) begin
         st_in[s] = div_step(st_ff[s-1]);
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_vld};
      end
   end

   assign out_vld  = vld_ff[DIV_STAGES-1];
   assign out_word = st_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: hdl/grid_cell_contour_segments.sv
// grid_cell_contour_segments: contour segments of one grid cell at one level
// depends on gccs_pkg and gccs_ratio_pipe
//
// Usage: req_ carries one cell (four corner samples, x/y bounds, level and
// level index) per item; rsp_ carries one segment per item, last_segment
// marking the final segment of a cell. A cell gives zero to four segments.
// Throughput: one segment per cycle while rsp_stall stays low. A cell holds the
// segment issue stage until its last segment is issued, and the next cell is
// taken only then; the single result channel and the issue stage set that rate.
// Each crossing point goes through a 16-stage divider (two quotient bits per
// stage), then one multiplier stage and one add stage.
// Reset clears all valid bits; no item is in flight afterward.
// When the receiver stalls a valid output item, the whole pipeline holds and req_stall rises;
// nothing is lost or repeated.
`default_nettype none

module grid_cell_contour_segments import gccs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  gccs_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output gccs_rsp_type rsp_payload
);

   typedef struct packed {
      logic [4:0][VAL_W-1:0] vx;
      logic [4:0][VAL_W-1:0] vy;
      logic [4:0][VAL_W-1:0] vv;
      logic [4:0][1:0]       cls;
      logic [VAL_W-1:0]      lvl;
      logic [LIDX_W-1:0]     lidx;
   } cell_type;

   typedef struct packed {
      logic [VAL_W-1:0] va;
      logic [VAL_W-1:0] vb;
      logic [VAL_W-1:0] xa;
      logic [VAL_W-1:0] xb;
      logic [VAL_W-1:0] ya;
      logic [VAL_W-1:0] yb;
   } rawpt_type;

   typedef struct packed {
      rawpt_type [1:0]   pt;
      logic [VAL_W-1:0]  lvl;
      logic [LIDX_W-1:0] lidx;
      logic              last;
   } tri_type;

   logic         rsp_valid_ff;
   gccs_rsp_type rsp_ff;
   gccs_rsp_type rsp_in;
   logic         adv;

   logic         a_vld_ff;
   gccs_req_type a_ff;
   logic         b_vld_ff;
   cell_type     b_ff;
   cell_type     b_in;
   logic [3:0]   rem_ff;
   logic [3:0]   mask_in;
   logic [3:0]   low_oh;
   logic [3:0]   rem_next;
   logic [1:0]   sel_t;
   logic         b_done;
   logic         t_vld_ff;
   tri_type      t_ff;
   tri_type      t_in;
   logic         p_vld_ff;
   gccs_div_type p_ff;
   gccs_div_type p_in;
   logic         d_vld;
   gccs_div_type d_word;
   logic         m_vld_ff;
   gccs_seg_type m_ff;
   gccs_seg_type m_in;

   // whole pipeline moves unless the output item is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(adv && (!a_vld_ff || b_done));

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv && (!a_vld_ff || b_done)) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && (!a_vld_ff || b_done)) begin
         a_ff <= req_payload;
      end
   end

   // centre vertex, vertex classes and triangle emit mask
   always_comb begin
      logic [VAL_W:0]   sx;
      logic [VAL_W:0]   sy;
      logic [VAL_W+1:0] sv;
      gccs_plan_type    pl;
      sx = {a_ff.x_left[VAL_W-1], a_ff.x_left} + {a_ff.x_right[VAL_W-1], a_ff.x_right};
      sy = {a_ff.y_low[VAL_W-1], a_ff.y_low} + {a_ff.y_high[VAL_W-1], a_ff.y_high};
      sv = {{2{a_ff.value_left_low[VAL_W-1]}}, a_ff.value_left_low}
         + {{2{a_ff.value_left_high[VAL_W-1]}}, a_ff.value_left_high}
         + {{2{a_ff.value_right_high[VAL_W-1]}}, a_ff.value_right_high}
         + {{2{a_ff.value_right_low[VAL_W-1]}}, a_ff.value_right_low};
      b_in.vx[0] = a_ff.x_left;
      b_in.vx[1] = a_ff.x_left;
      b_in.vx[2] = a_ff.x_right;
      b_in.vx[3] = a_ff.x_right;
      b_in.vx[4] = sx[VAL_W:1];
      b_in.vy[0] = a_ff.y_low;
      b_in.vy[1] = a_ff.y_high;
      b_in.vy[2] = a_ff.y_high;
      b_in.vy[3] = a_ff.y_low;
      b_in.vy[4] = sy[VAL_W:1];
      b_in.vv[0] = a_ff.value_left_low;
      b_in.vv[1] = a_ff.value_left_high;
      b_in.vv[2] = a_ff.value_right_high;
      b_in.vv[3] = a_ff.value_right_low;
      b_in.vv[4] = sv[VAL_W+1:2];
      b_in.lvl   = a_ff.level;
      b_in.lidx  = a_ff.level_index;
      for (int w = 0; w < 5; w++) begin
         if (b_in.vv[w] == a_ff.level) begin
            b_in.cls[w] = CLS_EQ;
         end else if ($signed(b_in.vv[w]) < $signed(a_ff.level)) begin
            b_in.cls[w] = CLS_BELOW;
         end else begin
            b_in.cls[w] = CLS_ABOVE;
         end
      end
      for (int t = 0; t < 4; t++) begin
         pl = tri_plan(gccs_cls_type'(b_in.cls[t]), gccs_cls_type'(b_in.cls[(t + 1) % 4]),
                       gccs_cls_type'(b_in.cls[4]));
         mask_in[t] = pl.emit;
      end
   end

   // segment issue: lowest remaining triangle first
   assign low_oh   = rem_ff & (~rem_ff + 4'd1);
   assign rem_next = rem_ff & ~low_oh;
   assign b_done   = !b_vld_ff || (rem_next == 4'd0);

   always_comb begin
      case (low_oh)
         4'b0010: sel_t = 2'd1;
         4'b0100: sel_t = 2'd2;
         4'b1000: sel_t = 2'd3;
         default: sel_t = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         rem_ff   <= 4'd0;
      end else if (adv) begin
         if (b_done) begin
            b_vld_ff <= a_vld_ff;
            rem_ff   <= a_vld_ff ? mask_in : 4'd0;
         end else begin
            rem_ff   <= rem_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && b_done) begin
         b_ff <= b_in;
      end
   end

   // pick the vertices of both segment ends
   always_comb begin
      gccs_plan_type pl;
      logic [2:0]    ia;
      logic [2:0]    ib;
      pl = tri_plan(gccs_cls_type'(b_ff.cls[sel_t]), gccs_cls_type'(b_ff.cls[sel_t + 2'd1]),
                    gccs_cls_type'(b_ff.cls[4]));
      ia = vidx(pl.a1, sel_t);
      ib = vidx(pl.b1, sel_t);
      t_in.pt[0].va = b_ff.vv[ia];
      t_in.pt[0].vb = b_ff.vv[ib];
      t_in.pt[0].xa = b_ff.vx[ia];
      t_in.pt[0].xb = b_ff.vx[ib];
      t_in.pt[0].ya = b_ff.vy[ia];
      t_in.pt[0].yb = b_ff.vy[ib];
      ia = vidx(pl.a2, sel_t);
      ib = vidx(pl.b2, sel_t);
      t_in.pt[1].va = b_ff.vv[ia];
      t_in.pt[1].vb = b_ff.vv[ib];
      t_in.pt[1].xa = b_ff.vx[ia];
      t_in.pt[1].xb = b_ff.vx[ib];
      t_in.pt[1].ya = b_ff.vy[ia];
      t_in.pt[1].yb = b_ff.vy[ib];
      t_in.lvl  = b_ff.lvl;
      t_in.lidx = b_ff.lidx;
      t_in.last = (rem_next == 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else if (adv) begin
         t_vld_ff <= b_vld_ff && (rem_ff != 4'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff <= t_in;
      end
   end

   // differences: numerator, denominator and coordinate offsets
   always_comb begin
      logic [VAL_W:0] dn;
      logic [VAL_W:0] dd;
      logic [VAL_W:0] dx;
      logic [VAL_W:0] dy;
      for (int j = 0; j < 2; j++) begin
         dn = {t_ff.pt[j].vb[VAL_W-1], t_ff.pt[j].vb} - {t_ff.lvl[VAL_W-1], t_ff.lvl};
         dd = {t_ff.pt[j].vb[VAL_W-1], t_ff.pt[j].vb} - {t_ff.pt[j].va[VAL_W-1], t_ff.pt[j].va};
         dx = {t_ff.pt[j].xa[VAL_W-1], t_ff.pt[j].xa} - {t_ff.pt[j].xb[VAL_W-1], t_ff.pt[j].xb};
         dy = {t_ff.pt[j].ya[VAL_W-1], t_ff.pt[j].ya} - {t_ff.pt[j].yb[VAL_W-1], t_ff.pt[j].yb};
         p_in.rem[j]          = mag33(dn);
         p_in.den[j]          = mag33(dd);
         p_in.quo[j]          = '0;
         p_in.seg.pt[j].cb_x  = t_ff.pt[j].xb;
         p_in.seg.pt[j].cb_y  = t_ff.pt[j].yb;
         p_in.seg.pt[j].mag_x = mag33(dx);
         p_in.seg.pt[j].mag_y = mag33(dy);
         p_in.seg.pt[j].neg_x = dx[VAL_W];
         p_in.seg.pt[j].neg_y = dy[VAL_W];
      end
      p_in.seg.lidx = t_ff.lidx;
      p_in.seg.last = t_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (adv) begin
         p_vld_ff <= t_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= p_in;
      end
   end

   // crossing fractions
   gccs_ratio_pipe u_ratio (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (p_vld_ff),
      .in_word  (p_ff),
      .out_vld  (d_vld),
      .out_word (d_word)
   );

   // offsets: magnitude times fraction, upper half
   always_comb begin
      logic [2*VAL_W-1:0] px;
      logic [2*VAL_W-1:0] py;
      m_in = d_word.seg;
      for (int j = 0; j < 2; j++) begin
         px = d_word.seg.pt[j].mag_x * d_word.quo[j];
         py = d_word.seg.pt[j].mag_y * d_word.quo[j];
         m_in.pt[j].mag_x = px[2*VAL_W-1:VAL_W];
         m_in.pt[j].mag_y = py[2*VAL_W-1:VAL_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= d_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff <= m_in;
      end
   end

   // apply offsets to the anchors
   always_comb begin
      rsp_in.x_start = m_ff.pt[0].neg_x ? m_ff.pt[0].cb_x - m_ff.pt[0].mag_x
                                        : m_ff.pt[0].cb_x + m_ff.pt[0].mag_x;
      rsp_in.y_start = m_ff.pt[0].neg_y ? m_ff.pt[0].cb_y - m_ff.pt[0].mag_y
                                        : m_ff.pt[0].cb_y + m_ff.pt[0].mag_y;
      rsp_in.x_end   = m_ff.pt[1].neg_x ? m_ff.pt[1].cb_x - m_ff.pt[1].mag_x
                                        : m_ff.pt[1].cb_x + m_ff.pt[1].mag_x;
      rsp_in.y_end   = m_ff.pt[1].neg_y ? m_ff.pt[1].cb_y - m_ff.pt[1].mag_y
                                        : m_ff.pt[1].cb_y + m_ff.pt[1].mag_y;
      rsp_in.segment_level = m_ff.lidx;
      rsp_in.last_segment  = m_ff.last;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // an empty issue stage holds no pending triangles
   a_rem_empty: assert property (@(posedge clock) disable iff (reset)
      !b_vld_ff |-> rem_ff == 4'd0)
      else $error("pending triangles without a cell");

   // each issue retires exactly one triangle
   a_issue_one: assert property (@(posedge clock) disable iff (reset)
      (adv && !b_done) |=> $countones(rem_ff) == $countones($past(rem_ff)) - 1)
      else $error("issue did not retire exactly one triangle");

   // a stalled output item is not replaced
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled output item changed");
`endif

endmodule

`default_nettype wire

// File: tb/gccs_checker.sv
// gccs_checker: watches the cell and segment channels of the contour block,
// predicts the segments of each accepted cell and compares them in order
// depends on gccs_pkg
`default_nettype none

module gccs_checker import gccs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  gccs_req_type req_payload,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  gccs_rsp_type rsp_payload,
   output int           fail_count,
   output int           pending_segments,
   output int           segments_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   gccs_rsp_type segment_queue[$];

   // sign of a vertex against the level: -1, 0, 1
   function automatic int side_of(longint v, longint lvl);
      if (v == lvl) return 0;
      return (v < lvl) ? -1 : 1;
   endfunction

   // one end point: a vertex (a == b) or the crossing between a and b anchored at b
   function automatic void end_point(int a, int b, longint lvl, longint vx[5],
                                     longint vy[5], longint vv[5],
                                     output longint px, output longint py);
      longint n, d, ca, cb, diff;
      bit [63:0] un, ud, r, frac, mag, off;
      int ci;
      if (a == b) begin
         px = vx[a];
         py = vy[a];
         return;
      end
      n = vv[b] - lvl;
      d = vv[b] - vv[a];
      if (d == 0) begin
         px = vx[b];
         py = vy[b];
         return;
      end
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      if (un >= ud) un = ud - 1;
      frac = 0;
      r = un;
      for (int i = 0; i < 32; i++) begin
         r = r << 1;
         frac = frac << 1;
         if (r >= ud) begin
            r = r - ud;
            frac[0] = 1'b1;
         end
      end
      for (ci = 0; ci < 2; ci++) begin
         ca = (ci == 0) ? vx[a] : vy[a];
         cb = (ci == 0) ? vx[b] : vy[b];
         diff = ca - cb;
         mag = (diff < 0) ? -diff : diff;
         off = (mag * frac) >> 32;
         if (ci == 0) px = (diff < 0) ? cb - longint'(off) : cb + longint'(off);
         else py = (diff < 0) ? cb - longint'(off) : cb + longint'(off);
      end
   endfunction

   // segments of one cell at one level, in triangle order
   function automatic void predict_cell(gccs_req_type c);
      longint vx[5], vy[5], vv[5], lvl, s;
      int side[5];
      int p, q, code, a1, b1, a2, b2, n0;
      longint x1, y1, x2, y2;
      gccs_rsp_type seg;
      vv[0] = longint'(signed'(c.value_left_low));
      vv[1] = longint'(signed'(c.value_left_high));
      vv[2] = longint'(signed'(c.value_right_high));
      vv[3] = longint'(signed'(c.value_right_low));
      vx[0] = longint'(signed'(c.x_left));
      vx[1] = vx[0];
      vx[2] = longint'(signed'(c.x_right));
      vx[3] = vx[2];
      vy[0] = longint'(signed'(c.y_low));
      vy[3] = vy[0];
      vy[1] = longint'(signed'(c.y_high));
      vy[2] = vy[1];
      vx[4] = (vx[0] + vx[2]) >>> 1;
      vy[4] = (vy[0] + vy[1]) >>> 1;
      s = vv[0] + vv[1] + vv[2] + vv[3];
      vv[4] = s >>> 2;
      lvl = longint'(signed'(c.level));
      for (int w = 0; w < 5; w++) side[w] = side_of(vv[w], lvl);
      n0 = segment_queue.size();
      for (int t = 0; t < 4; t++) begin
         p = t;
         q = (t + 1) % 4;
         code = side[p] + 4 * side[q] + 16 * side[4];
         case (code)
            16, -16, 0: begin a1 = p; b1 = p; a2 = q; b2 = q; end
            4, -4:      begin a1 = p; b1 = p; a2 = 4; b2 = 4; end
            1, -1:      begin a1 = q; b1 = q; a2 = 4; b2 = 4; end
            12, -12:    begin a1 = p; b1 = p; a2 = q; b2 = 4; end
            15, -15:    begin a1 = q; b1 = q; a2 = p; b2 = 4; end
            3, -3:      begin a1 = 4; b1 = 4; a2 = p; b2 = q; end
            19, -19:    begin a1 = p; b1 = q; a2 = p; b2 = 4; end
            13, -13:    begin a1 = q; b1 = p; a2 = q; b2 = 4; end
            11, -11:    begin a1 = 4; b1 = p; a2 = 4; b2 = q; end
            default:    continue;
         endcase
         end_point(a1, b1, lvl, vx, vy, vv, x1, y1);
         end_point(a2, b2, lvl, vx, vy, vv, x2, y2);
         seg.x_start       = x1[31:0];
         seg.y_start       = y1[31:0];
         seg.x_end         = x2[31:0];
         seg.y_end         = y2[31:0];
         seg.segment_level = c.level_index;
         seg.last_segment  = 1'b0;
         segment_queue.push_back(seg);
      end
      if (segment_queue.size() > n0)
         segment_queue[segment_queue.size()-1].last_segment = 1'b1;
   endfunction

   // predict on accepted cells, compare accepted segments
   always @(posedge clock) begin
      gccs_rsp_type want;
      if (reset) begin
         fail_count       <= 0;
         segments_seen    <= 0;
         pending_segments <= 0;
         segment_queue.delete();
      end else begin
         if (req_valid && !req_stall) predict_cell(req_payload);
         if (rsp_valid && !rsp_stall) begin
            segments_seen <= segments_seen + 1;
            if (segment_queue.size() == 0) begin
               $display("%0t: segment with none expected, actual %h", $time, rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = segment_queue.pop_front();
               if (want !== rsp_payload) begin
                  $display("%0t: segment mismatch, expected %h actual %h",
                           $time, want, rsp_payload);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_segments <= segment_queue.size();
      end
   end
endmodule

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: stimulus, idling and verdict for grid_cell_contour_segments
// depends on gccs_pkg, gccs_checker and the block itself
`default_nettype none

module tb_top import gccs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   gccs_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   gccs_rsp_type rsp_payload;
   int           fail_count, pending_segments, segments_seen;
   int           cycle_count = 0;
   int           send_idle_pct = 0, recv_idle_pct = 0;
   bit           hold_receiver = 1'b0;
   int           cells_sent = 0;

   grid_cell_contour_segments dut (.*);

   gccs_checker checker_i (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver stall, random or held for a long stretch
   always @(posedge clock) begin
      if (hold_receiver) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(7) - 3;
         3: return {16'($urandom_range(15) - 8), 16'h0};
         default: return $urandom;
      endcase
   endfunction

   // well-formed cell: small values around a level, often hitting it exactly
   function automatic gccs_req_type rand_cell();
      gccs_req_type c;
      logic [31:0] lvl;
      lvl = $urandom_range(3) == 0 ? rand_value() : ({16'($urandom_range(7) - 4), 16'h0});
      c.level = lvl;
      c.value_left_low   = ($urandom_range(3) == 0) ? lvl : lvl + $urandom_range(8192) - 4096;
      c.value_left_high  = ($urandom_range(3) == 0) ? lvl : lvl + $urandom_range(8192) - 4096;
      c.value_right_high = ($urandom_range(3) == 0) ? lvl : lvl + $urandom_range(8192) - 4096;
      c.value_right_low  = ($urandom_range(3) == 0) ? lvl : lvl + $urandom_range(8192) - 4096;
      if ($urandom_range(4) == 0) begin
         c.value_left_low   = rand_value();
         c.value_right_high = rand_value();
      end
      c.x_left  = rand_value();
      c.x_right = rand_value();
      c.y_low   = rand_value();
      c.y_high  = rand_value();
      c.level_index = 8'($urandom);
      return c;
   endfunction

   function automatic gccs_req_type make_cell(logic [31:0] ll, lh, rh, rl, lvl);
      gccs_req_type c;
      c.value_left_low = ll;
      c.value_left_high = lh;
      c.value_right_high = rh;
      c.value_right_low = rl;
      c.x_left = 32'h0;
      c.x_right = 32'h0001_0000;
      c.y_low = 32'h0;
      c.y_high = 32'h0001_0000;
      c.level = lvl;
      c.level_index = 8'($urandom);
      return c;
   endfunction

   // offer one cell and wait for it to be taken; valid stays up for the next one
   task automatic send_cell(gccs_req_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cells_sent++;
   endtask

   // stop offering and wait until every predicted segment has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_segments != 0) @(posedge clock);
   endtask

   initial begin
      gccs_req_type c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: flat, single corners, edges, extremes
      send_cell(make_cell(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000));
      send_cell(make_cell(32'h0, 32'h20000, 32'h20000, 32'h20000, 32'h10000));
      send_cell(make_cell(32'h10000, 32'h10000, 32'h0, 32'h0, 32'h10000));
      send_cell(make_cell(32'h10000, 32'h0, 32'h20000, 32'h0, 32'h10000));
      send_cell(make_cell(32'h0, 32'h0, 32'h0, 32'h0, 32'h10000));
      send_cell(make_cell(32'h20000, 32'h20000, 32'h20000, 32'h20000, 32'h10000));
      send_cell(make_cell(32'h10000, 32'h20000, 32'h20000, 32'h20000, 32'h10000));
      send_cell(make_cell(32'h0, 32'h20000, 32'h0, 32'h20000, 32'h10000));
      send_cell(make_cell(32'h0, 32'h20000, 32'h10000, 32'h10000, 32'h10000));
      send_cell(make_cell(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0));
      send_cell(make_cell(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                          32'hffff_ffff));
      c = make_cell(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffe);
      c.x_left = 32'h7fff_ffff; c.x_right = 32'h8000_0000;
      c.y_low = 32'h8000_0000; c.y_high = 32'h7fff_ffff; c.level_index = 8'hff;
      send_cell(c);
      c = make_cell(32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'h1, 32'h0);
      c.x_left = 32'hffff_ffff; c.x_right = 32'hffff_ffff;
      c.y_low = 32'h0; c.y_high = 32'h0; c.level_index = 8'h00;
      send_cell(c);
      // long receiver hold while cells keep coming
      hold_receiver = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_receiver = 1'b0;
         end
         repeat (20) send_cell(rand_cell());
      join
      // pause until every segment is out
      wait_drained();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 47 : 0;
         recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 20 : 0;
         repeat (34) send_cell($urandom_range(9) == 0 ? gccs_req_type'({$urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 8'($urandom)})
            : rand_cell());
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d cells and checked %0d segments across three idling phases",
               cells_sent, segments_seen);
      if (fail_count == 0 && pending_segments == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

`default_nettype wire

// File: grid_cell_contour_segments.f
hdl/gccs_pkg.sv
hdl/gccs_ratio_pipe.sv
hdl/grid_cell_contour_segments.sv
tb/gccs_checker.sv
tb/tb_top.sv
